// File: rtl/core/message_fragment_header_gen_assert.svh
// assertion macros shared by the fragment header generator
// no dependencies; included by the modules that check their own logic
`ifndef MESSAGE_FRAGMENT_HEADER_GEN_ASSERT_SVH
`define MESSAGE_FRAGMENT_HEADER_GEN_ASSERT_SVH

// same-cycle implication
`define MFHG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mfhg check failed");

// next-cycle implication
`define MFHG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mfhg check failed");

`endif

// File: rtl/core/mfhg_pkg.sv
// shared types and constants of the fragment header generator
// no dependencies
`default_nettype none

package mfhg_pkg;

    localparam int PAYLOAD_BYTES = 1024;
    localparam int MAX_FRAGMENTS = 63;
    localparam int PAY_LOG2      = $clog2(PAYLOAD_BYTES);

    localparam int LEN_W  = 16;
    localparam int NUM_W  = 6;
    localparam int ID_W   = 32;
    localparam int RNG_W  = 64;
    localparam int ADDR_W = 4;

    localparam logic [RNG_W-1:0] GEN_Y_INIT = 64'd362436069;
    localparam logic [RNG_W-1:0] GEN_Z_INIT = 64'd521288629;

    localparam logic [ADDR_W-1:0] REG_RNG_SEED = 4'h0;

    typedef enum logic [1:0] {
        KIND_HDR_CONTENT = 2'd0,
        KIND_START       = 2'd1,
        KIND_FRAG        = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_FRAG
    } state_t;

    typedef struct packed {
        logic load_hdr;
        logic load_frag;
    } cmd_t;

    typedef struct packed {
        logic cur_last;
    } status_t;

    typedef struct packed {
        logic             load;
        logic [RNG_W-1:0] seed;
    } seed_cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/mfhg_cfg.sv
// configuration register block: seed register behind the apb-style port
// depends on mfhg_pkg
`default_nettype none

module mfhg_cfg
    import mfhg_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [RNG_W-1:0]  pwdata,
    output logic      [RNG_W-1:0]  prdata,
    output logic                   pready,
    output seed_cfg_t              seed_cfg
);

    logic [RNG_W-1:0] seed_reg;
    logic [RNG_W-1:0] seed_next;
    logic             sel_seed;
    logic             wr_seed;

    assign pready   = 1'b1;
    assign sel_seed = (paddr[ADDR_W-1] == REG_RNG_SEED[ADDR_W-1]);
    assign wr_seed  = psel && penable && pwrite && pready && sel_seed;

    always_comb begin
        seed_next = seed_reg;
        if (wr_seed) begin
            seed_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else begin
            seed_reg <= seed_next;
        end
    end

    assign prdata        = sel_seed ? seed_reg : '0;
    assign seed_cfg.load = wr_seed;
    assign seed_cfg.seed = pwdata;

endmodule

`default_nettype wire

// File: rtl/core/mfhg_ctrl.sv
// controller: sequences header and fragment words of one message
// depends on mfhg_pkg and the assertion macro header
`default_nettype none

`include "message_fragment_header_gen_assert.svh"

module mfhg_ctrl
    import mfhg_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    output cmd_t         cmd,
    input  wire status_t status
);

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_HDR;
                end
            end
            ST_HDR, ST_FRAG: begin
                if (m_ready) begin
                    state_next = status.cur_last ? ST_IDLE : ST_FRAG;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        cmd.load_hdr  = 1'b0;
        cmd.load_frag = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_hdr = s_valid;
            end
            ST_HDR, ST_FRAG: begin
                m_valid       = 1'b1;
                cmd.load_frag = m_ready && !status.cur_last;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `MFHG_ASSERT_NOW(a_ready_excl, aclk, aresetn, s_ready, !m_valid)
    `MFHG_ASSERT_NEXT(a_accept_shows, aclk, aresetn, s_valid && s_ready, m_valid)
    `MFHG_ASSERT_NEXT(a_last_frees, aclk, aresetn,
        m_valid && m_ready && status.cur_last, s_ready)

endmodule

`default_nettype wire

// File: rtl/core/mfhg_dp.sv
// datapath: fragment count, xorshift96 id generator, output word registers
// depends on mfhg_pkg and the assertion macro header
`default_nettype none

`include "message_fragment_header_gen_assert.svh"

module mfhg_dp
    import mfhg_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cmd_t              cmd,
    output status_t                status,
    input  wire seed_cfg_t         seed_cfg,
    input  wire logic [LEN_W-1:0]  in_length,
    output logic      [1:0]        out_kind,
    output logic      [ID_W-1:0]   out_id,
    output logic      [NUM_W-1:0]  out_num,
    output logic      [LEN_W-1:0]  out_len,
    output logic      [LEN_W-1:0]  out_off,
    output logic                   out_too_long,
    output logic                   out_last
);

    localparam logic [LEN_W:0] PAY_EXT = (LEN_W+1)'(PAYLOAD_BYTES);
    localparam logic [LEN_W:0] PAY_M1  = (LEN_W+1)'(PAYLOAD_BYTES - 1);
    localparam logic [LEN_W:0] MAX_EXT = (LEN_W+1)'(MAX_FRAGMENTS);

    logic [RNG_W-1:0] rng_x_reg, rng_x_next;
    logic [RNG_W-1:0] rng_y_reg, rng_y_next;
    logic [RNG_W-1:0] rng_z_reg, rng_z_next;

    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] idx_reg, idx_next;
    logic [NUM_W-1:0] cnt_reg, cnt_next;
    logic [ID_W-1:0]  id_reg, id_next;

    kind_t            kind_reg, kind_next;
    logic [ID_W-1:0]  oid_reg, oid_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] off_reg, off_next;
    logic             tl_reg, tl_next;
    logic             last_reg, last_next;

    logic [RNG_W-1:0] sh_a, sh_b, sh_c, gen_z;
    logic [LEN_W:0]   cnt_full;
    logic [LEN_W-1:0] flen;
    logic [NUM_W:0]   idx_inc;
    logic [31:0]      off_full;

    // xorshift96 step
    assign sh_a  = rng_x_reg ^ (rng_x_reg << 16);
    assign sh_b  = sh_a ^ (sh_a >> 5);
    assign sh_c  = sh_b ^ (sh_b << 1);
    assign gen_z = sh_c ^ rng_y_reg ^ rng_z_reg;

    assign cnt_full = ({1'b0, in_length} + PAY_M1) >> PAY_LOG2;
    assign flen     = ({1'b0, rem_reg} > PAY_EXT) ? PAY_EXT[LEN_W-1:0] : rem_reg;
    assign idx_inc  = {1'b0, idx_reg} + (NUM_W+1)'(1);
    assign off_full = 32'(idx_reg) << PAY_LOG2;

    always_comb begin
        rng_x_next = rng_x_reg;
        rng_y_next = rng_y_reg;
        rng_z_next = rng_z_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        id_next    = id_reg;
        kind_next  = kind_reg;
        oid_next   = oid_reg;
        num_next   = num_reg;
        len_next   = len_reg;
        off_next   = off_reg;
        tl_next    = tl_reg;
        last_next  = last_reg;

        if (seed_cfg.load) begin
            rng_x_next = seed_cfg.seed;
            rng_y_next = GEN_Y_INIT;
            rng_z_next = GEN_Z_INIT;
        end

        if (cmd.load_hdr) begin
            rem_next = in_length;
            idx_next = '0;
            cnt_next = cnt_full[NUM_W-1:0];
            off_next = '0;
            if (cnt_full > MAX_EXT) begin
                kind_next = KIND_HDR_CONTENT;
                oid_next  = '0;
                num_next  = '0;
                len_next  = '0;
                tl_next   = 1'b1;
                last_next = 1'b1;
            end else if (cnt_full == (LEN_W+1)'(1)) begin
                kind_next = KIND_HDR_CONTENT;
                oid_next  = '1;
                num_next  = NUM_W'(1);
                len_next  = in_length;
                tl_next   = 1'b0;
                last_next = 1'b1;
            end else begin
                kind_next  = KIND_START;
                oid_next   = gen_z[ID_W-1:0];
                id_next    = gen_z[ID_W-1:0];
                num_next   = cnt_full[NUM_W-1:0];
                len_next   = in_length;
                tl_next    = 1'b0;
                last_next  = (cnt_full == '0);
                rng_x_next = rng_y_reg;
                rng_y_next = rng_z_reg;
                rng_z_next = gen_z;
            end
        end

        if (cmd.load_frag) begin
            kind_next = KIND_FRAG;
            oid_next  = id_reg;
            num_next  = idx_reg;
            len_next  = flen;
            off_next  = off_full[LEN_W-1:0];
            tl_next   = 1'b0;
            last_next = (idx_inc == {1'b0, cnt_reg});
            rem_next  = rem_reg - flen;
            idx_next  = idx_inc[NUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rng_x_reg <= '0;
            rng_y_reg <= GEN_Y_INIT;
            rng_z_reg <= GEN_Z_INIT;
            last_reg  <= 1'b0;
            tl_reg    <= 1'b0;
        end else begin
            rng_x_reg <= rng_x_next;
            rng_y_reg <= rng_y_next;
            rng_z_reg <= rng_z_next;
            last_reg  <= last_next;
            tl_reg    <= tl_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        id_reg   <= id_next;
        kind_reg <= kind_next;
        oid_reg  <= oid_next;
        num_reg  <= num_next;
        len_reg  <= len_next;
        off_reg  <= off_next;
    end

    assign status.cur_last = last_reg;

    assign out_kind     = kind_reg;
    assign out_id       = oid_reg;
    assign out_num      = num_reg;
    assign out_len      = len_reg;
    assign out_off      = off_reg;
    assign out_too_long = tl_reg;
    assign out_last     = last_reg;

    `MFHG_ASSERT_NOW(a_cmd_excl, aclk, aresetn, cmd.load_hdr, !cmd.load_frag)
    `MFHG_ASSERT_NEXT(a_frag_kind, aclk, aresetn, cmd.load_frag, kind_reg == KIND_FRAG)
    `MFHG_ASSERT_NEXT(a_too_long_last, aclk, aresetn,
        cmd.load_hdr && (cnt_full > MAX_EXT), tl_reg && last_reg)

endmodule

`default_nettype wire

// File: rtl/core/message_fragment_header_gen.sv
// top level of the message fragment header generator
// depends on mfhg_pkg, mfhg_cfg, mfhg_ctrl and mfhg_dp
//
// usage:
//   the input channel (s_valid, s_ready, s_message_length) takes one message
//   length per word; the result channel (m_valid, m_ready, m_*) gives the
//   header words of that message, with m_last on the final one
//   a length that fits one payload gives one combined header word; a longer
//   one gives a start header with a fresh xorshift96 id and then one content
//   word per fragment; zero length gives a lone start header; a length that
//   needs too many fragments gives one word with m_too_long set
//   the first result word is shown in the cycle after acceptance, and
//   each further word in the cycle after the previous one is taken
//   throughput: one result word per cycle when the receiver never stalls; the
//   next length is taken in the idle state between messages; one message at a time
//   a stall on m_ready holds the current word and the whole sequence
//   reset (aresetn low, synchronous) clears the seed to zero, reloads the
//   generator and drops any message in flight; a seed write through the
//   apb-style port reloads the generator, and the user makes it while the block
//   is idle; the block itself does not enforce this
`default_nettype none

module message_fragment_header_gen
    import mfhg_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic        [LEN_W-1:0] s_message_length,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic             [1:0]       m_msg_kind,
    output logic signed      [ID_W-1:0]  m_msg_id,
    output logic             [NUM_W-1:0] m_frag_number,
    output logic             [LEN_W-1:0] m_length_field,
    output logic             [LEN_W-1:0] m_buffer_offset,
    output logic                         m_too_long,
    output logic                         m_last,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic       [ADDR_W-1:0] paddr,
    input  wire logic        [RNG_W-1:0] pwdata,
    output logic             [RNG_W-1:0] prdata,
    output logic                         pready
);

    cmd_t            cmd;
    status_t         status;
    seed_cfg_t       seed_cfg;
    logic [ID_W-1:0] out_id;

    mfhg_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .seed_cfg (seed_cfg)
    );

    mfhg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    mfhg_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .seed_cfg     (seed_cfg),
        .in_length    (s_message_length),
        .out_kind     (m_msg_kind),
        .out_id       (out_id),
        .out_num      (m_frag_number),
        .out_len      (m_length_field),
        .out_off      (m_buffer_offset),
        .out_too_long (m_too_long),
        .out_last     (m_last)
    );

    assign m_msg_id = $signed(out_id);

endmodule

`default_nettype wire

// File: verif/message_fragment_header_gen_test.sv
// testbench of the message fragment header generator: directed and random lengths,
// seed reloads, stalls on both sides and a long output hold-off, all checked word by word
// depends on mfhg_pkg and message_fragment_header_gen
`default_nettype none

module message_fragment_header_gen_test
    import mfhg_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        kind_t                   kind;
        logic signed [ID_W-1:0]  id;
        logic        [NUM_W-1:0] num;
        logic        [LEN_W-1:0] len;
        logic        [LEN_W-1:0] offset;
        logic                    too_long;
        logic                    last;
    } descriptor_t;

    logic                    aclk;
    logic                    aresetn          = 1'b0;
    logic                    s_valid          = 1'b0;
    logic                    s_ready;
    logic        [LEN_W-1:0] s_message_length = '0;
    logic                    m_valid;
    logic                    m_ready          = 1'b0;
    logic        [1:0]       m_msg_kind;
    logic signed [ID_W-1:0]  m_msg_id;
    logic        [NUM_W-1:0] m_frag_number;
    logic        [LEN_W-1:0] m_length_field;
    logic        [LEN_W-1:0] m_buffer_offset;
    logic                    m_too_long;
    logic                    m_last;
    logic                    psel             = 1'b0;
    logic                    penable          = 1'b0;
    logic                    pwrite           = 1'b0;
    logic       [ADDR_W-1:0] paddr            = '0;
    logic        [RNG_W-1:0] pwdata           = '0;
    logic        [RNG_W-1:0] prdata;
    logic                    pready;

    // id generator copy
    logic [RNG_W-1:0] gen_x = '0;
    logic [RNG_W-1:0] gen_y = GEN_Y_INIT;
    logic [RNG_W-1:0] gen_z = GEN_Z_INIT;

    descriptor_t expected_descriptors[$];
    int          error_count     = 0;
    int          hold_off_cycles = 0;
    bit          no_idle         = 1'b0;

    message_fragment_header_gen dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_message_length (s_message_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_msg_kind       (m_msg_kind),
        .m_msg_id         (m_msg_id),
        .m_frag_number    (m_frag_number),
        .m_length_field   (m_length_field),
        .m_buffer_offset  (m_buffer_offset),
        .m_too_long       (m_too_long),
        .m_last           (m_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    initial begin
        #200ms;
        $display("message_fragment_header_gen regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= 100)
            $display("%0t: %s got %0h, expected %0h", $time, field, got, want);
    endtask

    function automatic logic [RNG_W-1:0] next_generator_word();
        logic [RNG_W-1:0] t;
        gen_x ^= gen_x << 16;
        gen_x ^= gen_x >> 5;
        gen_x ^= gen_x << 1;
        t = gen_x;
        gen_x = gen_y;
        gen_y = gen_z;
        gen_z = t ^ gen_x ^ gen_y;
        return gen_z;
    endfunction

    function automatic void queue_descriptor(input kind_t kind, input logic [ID_W-1:0] id,
                                             input int num, input int len, input int offset,
                                             input bit too_long, input bit last);
        descriptor_t d;
        d.kind     = kind;
        d.id       = id;
        d.num      = num[NUM_W-1:0];
        d.len      = len[LEN_W-1:0];
        d.offset   = offset[LEN_W-1:0];
        d.too_long = too_long;
        d.last     = last;
        expected_descriptors.push_back(d);
    endfunction

    function automatic void predict_fragments(input logic [LEN_W-1:0] msg_len);
        int               total;
        int               count;
        int               rest;
        int               piece;
        logic [RNG_W-1:0] word;
        logic [ID_W-1:0]  id;
        total = msg_len;
        count = (total + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES;
        if (count > MAX_FRAGMENTS) begin
            queue_descriptor(KIND_HDR_CONTENT, '0, 0, 0, 0, 1'b1, 1'b1);
            return;
        end
        if (count == 1) begin
            queue_descriptor(KIND_HDR_CONTENT, '1, 1, total, 0, 1'b0, 1'b1);
            return;
        end
        word = next_generator_word();
        id = word[ID_W-1:0];
        queue_descriptor(KIND_START, id, count, total, 0, 1'b0, count == 0);
        rest = total;
        for (int i = 0; i < count; i++) begin
            piece = (rest > PAYLOAD_BYTES) ? PAYLOAD_BYTES : rest;
            rest -= piece;
            queue_descriptor(KIND_FRAG, id, i, piece, i * PAYLOAD_BYTES, 1'b0, i + 1 == count);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 22)
            return LEN_W'($urandom_range(1, PAYLOAD_BYTES));
        if (r < 70)
            return LEN_W'($urandom_range(PAYLOAD_BYTES + 1, 8 * PAYLOAD_BYTES));
        if (r < 78)
            return LEN_W'($urandom_range(8 * PAYLOAD_BYTES + 1, MAX_FRAGMENTS * PAYLOAD_BYTES));
        if (r < 86)
            return LEN_W'($urandom_range(MAX_FRAGMENTS * PAYLOAD_BYTES + 1, 65535));
        if (r < 92) begin
            k = $urandom_range(1, MAX_FRAGMENTS);
            return LEN_W'(k * PAYLOAD_BYTES + $urandom_range(0, 2) - 1);
        end
        return LEN_W'($urandom_range(0, 65535));
    endfunction

    task automatic push_length(input logic [LEN_W-1:0] msg_len);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_message_length <= msg_len;
        do @(posedge aclk); while (!s_ready);
        predict_fragments(msg_len);
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_descriptors.size() != 0 && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_descriptors.size() != 0) begin
            report_mismatch("words never delivered", 0, expected_descriptors.size());
            expected_descriptors.delete();
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [RNG_W-1:0] seed);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_RNG_SEED;
        pwdata <= seed;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        gen_x = seed;
        gen_y = GEN_Y_INIT;
        gen_z = GEN_Z_INIT;
    endtask

    // receiver: random stalls, or a long hold-off when one is requested
    initial begin
        int run;
        forever begin
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                m_ready <= 1'b0;
                run = hold_off_cycles;
                hold_off_cycles = 0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
            end else begin
                m_ready <= 1'b1;
                run = 1;
            end
            repeat (run - 1) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        descriptor_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_descriptors.size() == 0) begin
                report_mismatch("unexpected word, kind", m_msg_kind, 0);
            end else begin
                want = expected_descriptors.pop_front();
                if (m_msg_kind !== want.kind)
                    report_mismatch("msg_kind", m_msg_kind, want.kind);
                if (m_msg_id !== want.id)
                    report_mismatch("msg_id", m_msg_id, want.id);
                if (m_frag_number !== want.num)
                    report_mismatch("frag_number", m_frag_number, want.num);
                if (m_length_field !== want.len)
                    report_mismatch("length_field", m_length_field, want.len);
                if (m_buffer_offset !== want.offset)
                    report_mismatch("buffer_offset", m_buffer_offset, want.offset);
                if (m_too_long !== want.too_long)
                    report_mismatch("too_long", m_too_long, want.too_long);
                if (m_last !== want.last)
                    report_mismatch("last", m_last, want.last);
            end
        end
    end

    task automatic test_directed_lengths();
        logic [LEN_W-1:0] lengths[$] = '{
            16'd0, 16'd1, 16'd2, 16'd1023, 16'd1024, 16'd1025, 16'd2047, 16'd2048,
            16'd2049, 16'd4097, 16'h5555, 16'haaaa, 16'd62464, 16'd63488, 16'd63489,
            16'd64511, 16'd64512, 16'd64513, 16'd65024, 16'hffff
        };
        foreach (lengths[i])
            push_length(lengths[i]);
        wait_idle();
    endtask

    task automatic test_seed_reload();
        logic [RNG_W-1:0] seeds[$];
        seeds = '{'1, '0, {$urandom, $urandom}};
        foreach (seeds[i]) begin
            write_seed(seeds[i]);
            push_length(16'd5000);
            push_length(16'd0);
            wait_idle();
        end
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (16)
            push_length(LEN_W'($urandom_range(PAYLOAD_BYTES + 1, 6 * PAYLOAD_BYTES)));
        wait_idle();
        no_idle = 1'b0;
    endtask

    task automatic test_output_hold_off();
        hold_off_cycles = 300;
        repeat (6)
            push_length(LEN_W'($urandom_range(2 * PAYLOAD_BYTES + 1, 8 * PAYLOAD_BYTES)));
        wait_idle();
    endtask

    task automatic test_random_lengths();
        logic [RNG_W-1:0] seeds[$];
        seeds = '{64'h8000_0000_0000_0000, 64'd1, {$urandom, $urandom}, '1,
                  {$urandom, $urandom}};
        foreach (seeds[i]) begin
            write_seed(seeds[i]);
            repeat (56)
                push_length(pick_length());
            wait_idle();
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_directed_lengths();
        test_seed_reload();
        test_back_to_back();
        test_output_hold_off();
        test_random_lengths();

        repeat (20) @(posedge aclk);
        if (error_count == 0)
            $display("message_fragment_header_gen regression: pass");
        else
            $display("message_fragment_header_gen regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl/core
rtl/core/mfhg_pkg.sv
rtl/core/mfhg_cfg.sv
rtl/core/mfhg_ctrl.sv
rtl/core/mfhg_dp.sv
rtl/core/message_fragment_header_gen.sv
verif/message_fragment_header_gen_test.sv
